// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BYTE_W = 8;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [4:0] hash_t;

	localparam hash_t INIT_HASH = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;

	localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

	localparam logic [6:0] LEN_OFFSET = 7'd56;
	localparam logic [6:0] RND_PH1    = 7'd20;
	localparam logic [6:0] RND_PH2    = 7'd40;
	localparam logic [6:0] RND_PH3    = 7'd60;
	localparam logic [6:0] RND_LAST   = 7'd79;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MARK  = 7'b0000010,
		S_ZPAD  = 7'b0000100,
		S_LEN   = 7'b0001000,
		S_ROUND = 7'b0010000,
		S_HADD  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic add;
		logic init;
	} rnd_cmd_t;

endpackage

// ===== rtl/core/sha1_in_if.sv =====
// ----------------------------------------------------------------------------
// sha1_in_if
// Message byte channel: valid/ready with byte, byte flag and end flag.
// ----------------------------------------------------------------------------
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_valid;
	logic       last_byte;

	modport source (output valid, msg_byte, byte_valid, last_byte, input ready);
	modport sink   (input valid, msg_byte, byte_valid, last_byte, output ready);
endinterface

// ===== rtl/core/sha1_out_if.sv =====
// ----------------------------------------------------------------------------
// sha1_out_if
// Digest channel: valid/ready with the five digest words.
// ----------------------------------------------------------------------------
interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, digest_word0, digest_word1, digest_word2,
		digest_word3, digest_word4, input ready);
	modport sink   (input valid, digest_word0, digest_word1, digest_word2,
		digest_word3, digest_word4, output ready);
endinterface

// ===== rtl/core/sha1_hash_engine_unit.sv =====
// A byte that does not fill the block only shifts into the buffer; the 64th byte
// of a block also starts compression: the rounds on the shared round unit, then
// the hash add. Closing: the pad and length bytes shift in, the zero pad moves
// on to the length field, each block (one or two) is compressed, and the digest
// register is loaded. Intake is not ready while a block is compressed.
// Reset restores the initial hash and clears counts; the buffer is not cleared.
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 engine: byte intake, padding sequencer, iterative compression.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit
	import sha1_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	sha1_in_if.sink    msg,
	sha1_out_if.source digest
);

	state_t      state_q, ret_q;
	logic [6:0]  fill_q;
	logic [63:0] cnt_q;
	logic [6:0]  rnd_q;
	logic        out_valid_q;
	hash_t       dig_q;

	logic        accept;
	logic        out_free;
	logic [6:0]  fill_inc;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic        buf_shift;
	logic [7:0]  buf_byte;
	rnd_cmd_t    cmd;
	word_t       w_cur;
	hash_t       hash;

	assign msg.ready  = (state_q == S_IDLE);
	assign accept     = msg.valid && msg.ready;
	assign out_free   = !out_valid_q || digest.ready;
	assign fill_inc   = fill_q + 7'd1;
	assign bit_len    = {cnt_q[60:0], 3'b000};
	assign len_byte   = 8'(bit_len >> {~fill_q[2:0], 3'b000});

	assign digest.valid        = out_valid_q;
	assign digest.digest_word0 = dig_q[0];
	assign digest.digest_word1 = dig_q[1];
	assign digest.digest_word2 = dig_q[2];
	assign digest.digest_word3 = dig_q[3];
	assign digest.digest_word4 = dig_q[4];

	always_comb begin
		buf_shift = 1'b0;
		buf_byte  = msg.msg_byte;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && msg.byte_valid) begin
					buf_shift = 1'b1;
					cmd.load  = fill_inc[6];
				end
			end
			S_MARK: begin
				buf_shift = 1'b1;
				buf_byte  = PAD_MARK;
				cmd.load  = fill_inc[6];
			end
			S_ZPAD: begin
				if (fill_q != LEN_OFFSET) begin
					buf_shift = 1'b1;
					buf_byte  = '0;
					cmd.load  = fill_inc[6];
				end
			end
			S_LEN: begin
				buf_shift = 1'b1;
				buf_byte  = len_byte;
				cmd.load  = fill_inc[6];
			end
			S_ROUND: cmd.step = 1'b1;
			S_HADD:  cmd.add  = 1'b1;
			S_FIN:   cmd.init = out_free;
			default: cmd = '0;
		endcase
	end

	sha1_msg_buf u_buf (
		.clk        (clk),
		.shift_byte (buf_shift),
		.byte_in    (buf_byte),
		.shift_word (cmd.step),
		.w_out      (w_cur)
	);

	sha1_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rnd_idx (rnd_q),
		.w_in    (w_cur),
		.hash    (hash)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			dig_q <= hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (digest.valid && digest.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				rnd_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (msg.byte_valid) begin
							fill_q <= fill_inc;
							cnt_q  <= cnt_q + 64'd1;
							if (fill_inc[6]) begin
								state_q <= S_ROUND;
								ret_q   <= msg.last_byte ? S_MARK : S_IDLE;
							end else if (msg.last_byte) begin
								state_q <= S_MARK;
							end
						end else if (msg.last_byte) begin
							state_q <= S_MARK;
						end
					end
				end
				S_MARK: begin
					fill_q <= fill_inc;
					if (fill_inc[6]) begin
						state_q <= S_ROUND;
						ret_q   <= S_ZPAD;
					end else begin
						state_q <= S_ZPAD;
					end
				end
				S_ZPAD: begin
					if (fill_q == LEN_OFFSET) begin
						state_q <= S_LEN;
					end else begin
						fill_q <= fill_inc;
						if (fill_inc[6]) begin
							state_q <= S_ROUND;
							ret_q   <= S_ZPAD;
						end
					end
				end
				S_LEN: begin
					fill_q <= fill_inc;
					if (fill_inc[6]) begin
						state_q <= S_ROUND;
						ret_q   <= S_FIN;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == RND_LAST) begin
						state_q <= S_HADD;
					end
				end
				S_HADD: begin
					fill_q  <= '0;
					state_q <= ret_q;
				end
				S_FIN: begin
					if (out_free) begin
						cnt_q   <= '0;
						fill_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/sha1_msg_buf.sv =====
// ----------------------------------------------------------------------------
// sha1_msg_buf
// 64-byte block buffer; bytes shift in big-endian, then the same register
// runs as the 16-word message schedule window during compression.
// ----------------------------------------------------------------------------
module sha1_msg_buf
	import sha1_pkg::*;
(
	input  logic              clk,
	input  logic              shift_byte,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic              shift_word,
	output word_t             w_out
);

	logic [511:0] blk_q;
	word_t        w_new;
	word_t        w_mix;

	assign w_out = blk_q[511 -: 32];
	assign w_mix = blk_q[511-32*13 -: 32] ^ blk_q[511-32*8 -: 32] ^
		blk_q[511-32*2 -: 32] ^ blk_q[511 -: 32];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk) begin
		if (shift_word) begin
			blk_q <= {blk_q[479:0], w_new};
		end else if (shift_byte) begin
			blk_q <= {blk_q[503:0], byte_in};
		end
	end

endmodule

// ===== rtl/core/sha1_round.sv =====
// ----------------------------------------------------------------------------
// sha1_round
// Shared SHA-1 round unit: working registers a..e, one round per step,
// and the running hash with its end-of-block add.
// ----------------------------------------------------------------------------
module sha1_round
	import sha1_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rnd_cmd_t cmd,
	input  logic [6:0] rnd_idx,
	input  word_t    w_in,
	output hash_t    hash
);

	hash_t hash_q;
	word_t a_q, b_q, c_q, d_q, e_q;
	word_t f_fn;
	word_t k_c;
	word_t t_sum;

	assign hash = hash_q;

	always_comb begin
		if (rnd_idx < RND_PH1) begin
			f_fn = (b_q & c_q) | (~b_q & d_q);
			k_c  = K_R0;
		end else if (rnd_idx < RND_PH2) begin
			f_fn = b_q ^ c_q ^ d_q;
			k_c  = K_R1;
		end else if (rnd_idx < RND_PH3) begin
			f_fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_c  = K_R2;
		end else begin
			f_fn = b_q ^ c_q ^ d_q;
			k_c  = K_R3;
		end
		t_sum = {a_q[26:0], a_q[31:27]} + f_fn + e_q + k_c + w_in;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
		end else if (cmd.step) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= INIT_HASH;
		end else if (cmd.init) begin
			hash_q <= INIT_HASH;
		end else if (cmd.add) begin
			hash_q[0] <= hash_q[0] + a_q;
			hash_q[1] <= hash_q[1] + b_q;
			hash_q[2] <= hash_q[2] + c_q;
			hash_q[3] <= hash_q[3] + d_q;
			hash_q[4] <= hash_q[4] + e_q;
		end
	end

endmodule

// ===== rtl/core/sha1_hash_engine_unit_chk.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit_chk
// Port-level checks for the SHA-1 engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word0
);

	// stalled digest transfer keeps valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("digest valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word0))
		else $error("digest word changed while stalled");

	// closing a message keeps intake busy at the start of padding
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready)
		else $error("intake ready during padding");

	// a new digest only follows a busy finishing cycle
	a_digest_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("digest appeared without finishing");

endmodule

bind sha1_hash_engine_unit sha1_hash_engine_unit_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_last   (msg.last_byte),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.out_word0 (digest.digest_word0)
);
